### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/core/ntnb_pkg.sv
// ----------------------------------------------------------------------------
// ntnb_pkg
// Types and constants of the needle tip and nearest bead finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntnb_pkg;

   // Frame geometry and limits.
   localparam int unsigned FRAME_WIDTH      = 1344;
   localparam int unsigned FRAME_HEIGHT     = 1024;
   localparam int unsigned MAX_BEADS_DEF    = 256;
   localparam int unsigned NONE_DIST        = 15984;

   // Field widths.
   localparam int unsigned X_W     = 11;
   localparam int unsigned Y_W     = 10;
   localparam int unsigned SIZE_W  = 11;
   localparam int unsigned SCALE_W = 16;
   localparam int unsigned DIST_W  = 14;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned COUNT_W = 9;

   // Configuration register reset values.
   localparam logic [Y_W-1:0]     BAND_TOP_RST  = '0;
   localparam logic [SIZE_W-1:0]  BAND_SIZE_RST = SIZE_W'(256);
   localparam logic [SCALE_W-1:0] SCALE_RST     = SCALE_W'(2642);

   // Register word indexes on the configuration port.
   localparam logic [1:0] REG_BAND_TOP  = 2'd0;
   localparam logic [1:0] REG_BAND_SIZE = 2'd1;
   localparam logic [1:0] REG_SCALE     = 2'd2;

   // Report kinds.
   localparam logic REPORT_TIP  = 1'b0;
   localparam logic REPORT_BEAD = 1'b1;

   // Input item operation codes.
   typedef enum logic [1:0] {
      OP_PIXEL    = 2'd0,
      OP_MASK_END = 2'd1,
      OP_BEAD     = 2'd2,
      OP_BEAD_END = 2'd3
   } op_type;

   typedef struct packed {
      op_type           operation;
      logic [X_W-1:0]   coord_x;
      logic [Y_W-1:0]   coord_y;
      logic             mask_bit;
   } req_item_type;

   typedef struct packed {
      logic               report_kind;
      logic [X_W-1:0]     tip_x;
      logic [Y_W-1:0]     tip_y;
      logic               tip_found;
      logic [DIST_W-1:0]  distance_um;
      logic [INDEX_W-1:0] closest_index;
      logic               bead_found;
      logic [COUNT_W-1:0] bead_count;
   } rsp_item_type;

endpackage

### rtl/core/needle_tip_nearest_bead.sv
// ----------------------------------------------------------------------------
// needle_tip_nearest_bead
// Finds the needle tip in a streamed mask frame and the bead nearest to it.
// ----------------------------------------------------------------------------
// Items arrive on the req_ channel (valid/stall) and reports leave on the
// rsp_ channel. A mask pixel item does not occupy the sequencer, so a frame
// streams at one pixel a clock while the block is idle and no report waits
// under rsp_stall. An end of mask item loads a tip report into the output
// register. A bead outside the band, or beyond the bead limit, leaves the
// sequencer idle. A bead inside the band occupies the shared 24x16 multiplier
// and then the bit-serial square root, during which req_stall stays high.
// An end of beads item loads the nearest bead report.
// Reports appear on the cycle after the closing item is accepted. While a
// report waits under rsp_stall, new items are held off; a report that is
// taken in the same cycle frees the slot at once.
// Reset (synchronous, active high) returns the registers to their reset
// values, clears the tip and bead search state and empties the output.
// The csr_ port writes band_top, band_size and um_per_pixel at byte
// addresses 0, 4 and 8 and should be written only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module needle_tip_nearest_bead #(
   parameter int unsigned MAX_BEADS = ntnb_pkg::MAX_BEADS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input item channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ntnb_pkg::req_item_type req_data,
   // Report channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ntnb_pkg::rsp_item_type rsp_data,
   // Configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import ntnb_pkg::*;

   localparam int unsigned CNT_W      = $clog2(MAX_BEADS + 1);
   localparam int unsigned D2_W       = 23;
   localparam int unsigned MUL_A_W    = 24;
   localparam int unsigned MUL_P_W    = MUL_A_W + SCALE_W;
   localparam int unsigned P1_W       = D2_W + SCALE_W;
   localparam int unsigned HI_W       = P1_W - MUL_A_W + SCALE_W;
   localparam int unsigned RAD_W      = 55;
   localparam int unsigned ROOT_W     = RAD_W + 1;
   localparam int unsigned ROOT_STEPS = (RAD_W + 1) / 2;
   localparam int unsigned STEP_W     = $clog2(ROOT_STEPS);
   localparam int unsigned Q_W        = 20;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SCALE,
      ST_LOW,
      ST_HIGH,
      ST_SUM,
      ST_ROOT,
      ST_CMP
   } state_type;

   // Configuration registers
   logic [Y_W-1:0]     band_top_ff, band_top_in;
   logic [SIZE_W-1:0]  band_size_ff, band_size_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;

   // Search state
   logic [X_W-1:0]     best_x_ff, best_x_in;
   logic [Y_W-1:0]     best_y_ff, best_y_in;
   logic               tip_seen_ff, tip_seen_in;
   logic [X_W-1:0]     tip_x_ff, tip_x_in;
   logic [Y_W-1:0]     tip_y_ff, tip_y_in;
   logic [DIST_W-1:0]  min_dist_ff, min_dist_in;
   logic [INDEX_W-1:0] min_index_ff, min_index_in;
   logic [CNT_W-1:0]   bead_cnt_ff, bead_cnt_in;

   // Sequencer and datapath registers
   state_type          state_ff, state_in;
   logic [X_W-1:0]     dx_ff, dx_in;
   logic [Y_W-1:0]     dy_ff, dy_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [D2_W-1:0]    d2_ff, d2_in;
   logic [P1_W-1:0]    p1_ff, p1_in;
   logic [MUL_P_W-1:0] lo_ff, lo_in;
   logic [HI_W-1:0]    hi_ff, hi_in;
   logic [RAD_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  res_ff, res_in;
   logic [ROOT_W-1:0]  bit_ff, bit_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   // Combinational helpers
   logic [SIZE_W:0]    band_end;
   logic               accept;
   logic               csr_write;
   logic               pix_in_band;
   logic               bead_in_band;
   logic [MUL_A_W-1:0] mul_a;
   logic [SCALE_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;
   logic [ROOT_W-1:0]  trial;
   logic [Q_W-1:0]     dist_q;

   assign band_end  = {1'b0, band_size_ff} + (SIZE_W + 1)'(band_top_ff);
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   assign pix_in_band = req_data.mask_bit
                        && (req_data.coord_x < X_W'(FRAME_WIDTH))
                        && ((Y_W + 1)'(req_data.coord_y) < (Y_W + 1)'(FRAME_HEIGHT))
                        && (req_data.coord_y >= band_top_ff)
                        && ((SIZE_W + 1)'(req_data.coord_y) < band_end);
   assign bead_in_band = (req_data.coord_y > band_top_ff)
                         && ((SIZE_W + 1)'(req_data.coord_y) < band_end);

   // Register read-back.
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_BAND_TOP:  csr_prdata = 32'(band_top_ff);
         REG_BAND_SIZE: csr_prdata = 32'(band_size_ff);
         REG_SCALE:     csr_prdata = 32'(scale_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (state_ff)
         ST_SQX: begin
            mul_a = MUL_A_W'(dx_ff);
            mul_b = SCALE_W'(dx_ff);
         end
         ST_SQY: begin
            mul_a = MUL_A_W'(dy_ff);
            mul_b = SCALE_W'(dy_ff);
         end
         ST_SCALE: begin
            mul_a = MUL_A_W'(d2_ff);
            mul_b = scale_ff;
         end
         ST_LOW: begin
            mul_a = p1_ff[MUL_A_W-1:0];
            mul_b = scale_ff;
         end
         ST_HIGH: begin
            mul_a = MUL_A_W'(p1_ff[P1_W-1:MUL_A_W]);
            mul_b = scale_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   assign trial  = res_ff + bit_ff;
   assign dist_q = res_ff[Q_W+7:8];

   // Next-state logic.
   always_comb begin
      band_top_in  = band_top_ff;
      band_size_in = band_size_ff;
      scale_in     = scale_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      tip_seen_in  = tip_seen_ff;
      tip_x_in     = tip_x_ff;
      tip_y_in     = tip_y_ff;
      min_dist_in  = min_dist_ff;
      min_index_in = min_index_ff;
      bead_cnt_in  = bead_cnt_ff;
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      idx_in       = idx_ff;
      d2_in        = d2_ff;
      p1_in        = p1_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      step_in      = step_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // Configuration writes.
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_BAND_TOP:  band_top_in  = csr_pwdata[Y_W-1:0];
            REG_BAND_SIZE: band_size_in = csr_pwdata[SIZE_W-1:0];
            REG_SCALE:     scale_in     = csr_pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.operation)
                  OP_PIXEL: begin
                     // Keep the leftmost, then topmost, needle pixel in band.
                     if (pix_in_band && (!tip_seen_ff || req_data.coord_x < best_x_ff
                         || (req_data.coord_x == best_x_ff
                             && req_data.coord_y < best_y_ff))) begin
                        best_x_in   = req_data.coord_x;
                        best_y_in   = req_data.coord_y;
                        tip_seen_in = 1'b1;
                     end
                  end
                  OP_MASK_END: begin
                     tip_x_in    = tip_seen_ff ? best_x_ff : X_W'(FRAME_WIDTH);
                     tip_y_in    = tip_seen_ff ? best_y_ff : '0;
                     rsp_data_in = '0;
                     rsp_data_in.report_kind = REPORT_TIP;
                     rsp_data_in.tip_x       = tip_x_in;
                     rsp_data_in.tip_y       = tip_y_in;
                     rsp_data_in.tip_found   = tip_seen_ff;
                     rsp_valid_in = 1'b1;
                     best_x_in   = X_W'(FRAME_WIDTH);
                     best_y_in   = '0;
                     tip_seen_in = 1'b0;
                  end
                  OP_BEAD: begin
                     if (bead_cnt_ff < CNT_W'(MAX_BEADS)) begin
                        bead_cnt_in = bead_cnt_ff + CNT_W'(1);
                        idx_in      = INDEX_W'(bead_cnt_ff);
                        dx_in = (tip_x_ff > req_data.coord_x)
                                ? tip_x_ff - req_data.coord_x
                                : req_data.coord_x - tip_x_ff;
                        dy_in = (tip_y_ff > req_data.coord_y)
                                ? tip_y_ff - req_data.coord_y
                                : req_data.coord_y - tip_y_ff;
                        if (bead_in_band) begin
                           state_in = ST_SQX;
                        end
                     end
                  end
                  OP_BEAD_END: begin
                     rsp_data_in.report_kind   = REPORT_BEAD;
                     rsp_data_in.tip_x         = tip_x_ff;
                     rsp_data_in.tip_y         = tip_y_ff;
                     rsp_data_in.tip_found     = tip_x_ff < X_W'(FRAME_WIDTH);
                     rsp_data_in.distance_um   = min_dist_ff;
                     rsp_data_in.closest_index = min_index_ff;
                     rsp_data_in.bead_found    = min_dist_ff < DIST_W'(NONE_DIST);
                     rsp_data_in.bead_count    = COUNT_W'(bead_cnt_ff);
                     rsp_valid_in = 1'b1;
                     min_dist_in  = DIST_W'(NONE_DIST);
                     min_index_in = '0;
                     bead_cnt_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         // Squared distance in pixels.
         ST_SQX: begin
            d2_in    = mul_p[D2_W-1:0];
            state_in = ST_SQY;
         end
         ST_SQY: begin
            d2_in    = d2_ff + mul_p[D2_W-1:0];
            state_in = ST_SCALE;
         end
         // Scale twice by the pixel pitch, the second time in two halves.
         ST_SCALE: begin
            p1_in    = mul_p[P1_W-1:0];
            state_in = ST_LOW;
         end
         ST_LOW: begin
            lo_in    = mul_p;
            state_in = ST_HIGH;
         end
         ST_HIGH: begin
            hi_in    = mul_p[HI_W-1:0];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rem_in   = RAD_W'(lo_ff) + RAD_W'({hi_ff, {MUL_A_W{1'b0}}});
            res_in   = '0;
            bit_in   = ROOT_W'(1) << (RAD_W - 1);
            step_in  = '0;
            state_in = ST_ROOT;
         end
         // One result bit of the integer square root a cycle.
         ST_ROOT: begin
            if (ROOT_W'(rem_ff) >= trial) begin
               rem_in = rem_ff - trial[RAD_W-1:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ST_CMP;
            end
         end
         // Keep the first strict minimum.
         ST_CMP: begin
            if (dist_q < Q_W'(min_dist_ff)) begin
               min_dist_in  = dist_q[DIST_W-1:0];
               min_index_in = idx_ff;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         band_top_ff  <= BAND_TOP_RST;
         band_size_ff <= BAND_SIZE_RST;
         scale_ff     <= SCALE_RST;
         best_x_ff    <= X_W'(FRAME_WIDTH);
         best_y_ff    <= '0;
         tip_seen_ff  <= 1'b0;
         tip_x_ff     <= X_W'(FRAME_WIDTH);
         tip_y_ff     <= '0;
         min_dist_ff  <= DIST_W'(NONE_DIST);
         min_index_ff <= '0;
         bead_cnt_ff  <= '0;
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         band_top_ff  <= band_top_in;
         band_size_ff <= band_size_in;
         scale_ff     <= scale_in;
         best_x_ff    <= best_x_in;
         best_y_ff    <= best_y_in;
         tip_seen_ff  <= tip_seen_in;
         tip_x_ff     <= tip_x_in;
         tip_y_ff     <= tip_y_in;
         min_dist_ff  <= min_dist_in;
         min_index_ff <= min_index_in;
         bead_cnt_ff  <= bead_cnt_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      idx_ff      <= idx_in;
      d2_ff       <= d2_in;
      p1_ff       <= p1_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the sequencer and search state.
   `ASSERT_ALWAYS(a_busy_stalls, clock, reset, state_ff == ST_IDLE || req_stall, "busy without stall")
   `ASSERT_ALWAYS(a_min_range, clock, reset, min_dist_ff <= DIST_W'(NONE_DIST), "minimum out of range")
   `ASSERT_NEXT(a_bead_end_report, clock, reset, accept && req_data.operation == OP_BEAD_END, rsp_valid_ff && rsp_data_ff.report_kind == REPORT_BEAD, "no bead report")
   `ASSERT_NEXT(a_root_done, clock, reset, state_ff == ST_ROOT && step_ff == STEP_W'(ROOT_STEPS - 1), state_ff == ST_CMP, "root did not finish")

endmodule

### tb/sv/needle_tip_nearest_bead_tb.sv
// ----------------------------------------------------------------------------
// needle_tip_nearest_bead_tb
// Self-checking bench for the needle tip and nearest bead finder.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a clocked driver, and a clocked monitor
// predicts the reports of every accepted item and checks each report the
// block hands out against the oldest prediction. The run starts with a short
// directed frame under the reset settings, then goes through several band
// and scale settings with random frames and bead sets, random idling on
// both channels, one long hold-off on the report side and a final stretch
// without idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module needle_tip_nearest_bead_tb;

   import ntnb_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned SETTLE_CYCLES  = 60;
   localparam int unsigned SHOWN_ERRORS   = 10;
   localparam int unsigned LONG_HOLD      = 400;
   localparam int unsigned NUM_PHASES     = 7;
   localparam int unsigned PHASE_ITEMS    = 145;
   localparam int unsigned OVERFLOW_PHASE = 4;
   localparam int unsigned PRESSURE_PHASE = 5;

   // Clock, reset and block ports.
   logic           clock;
   logic           reset       = 1'b1;
   logic           req_valid   = 1'b0;
   logic           req_stall;
   req_item_type   req_data    = '0;
   logic           rsp_valid;
   logic           rsp_stall   = 1'b0;
   rsp_item_type   rsp_data;
   logic           csr_psel    = 1'b0;
   logic           csr_penable = 1'b0;
   logic           csr_pwrite  = 1'b0;
   logic [3:0]     csr_paddr   = '0;
   logic [31:0]    csr_pwdata  = '0;
   logic [31:0]    csr_prdata;
   logic           csr_pready;

   // Stimulus and checking bookkeeping.
   req_item_type   pending_items[$];
   rsp_item_type   expected_reports[$];
   logic           req_taken     = 1'b0;
   int unsigned    items_queued  = 0;
   int unsigned    mismatches    = 0;
   int unsigned    cycle_count   = 0;
   bit             calm          = 1'b0;
   bit             long_hold_req = 1'b0;
   int unsigned    send_gap      = 0;
   bit             send_idle_on  = 1'b1;
   int unsigned    recv_gap      = 0;
   bit             recv_idle_on  = 1'b1;
   int unsigned    hold_left     = 0;

   // Predicted register settings and search state.
   logic [Y_W-1:0]     band_first   = BAND_TOP_RST;
   logic [SIZE_W-1:0]  band_rows    = BAND_SIZE_RST;
   logic [SCALE_W-1:0] scale_q12    = SCALE_RST;
   logic [X_W-1:0]     cand_x       = X_W'(FRAME_WIDTH);
   logic [Y_W-1:0]     cand_y       = '0;
   logic               needle_seen  = 1'b0;
   logic [X_W-1:0]     tip_x_held   = X_W'(FRAME_WIDTH);
   logic [Y_W-1:0]     tip_y_held   = '0;
   logic [DIST_W-1:0]  nearest_dist = DIST_W'(NONE_DIST);
   logic [INDEX_W-1:0] nearest_idx  = '0;
   int unsigned        beads_seen   = 0;

   needle_tip_nearest_bead i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Integer square root, rounded down, by the digit-by-digit method.
   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned probe;
      rem   = n;
      res   = 0;
      probe = 64'd1 << 62;
      while (probe > rem)
         probe >>= 2;
      while (probe != 0) begin
         if (rem >= res + probe) begin
            rem -= res + probe;
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   // Advances the predicted search state by one accepted item and queues the
   // report that the item closes, if any.
   function automatic void predict_item(input req_item_type it);
      rsp_item_type    rep;
      int unsigned     band_end;
      int unsigned     slot;
      longint unsigned dx;
      longint unsigned dy;
      longint unsigned bead_dist;
      band_end = band_first + band_rows;
      rep = '0;
      case (it.operation)
         OP_PIXEL: begin
            if (it.mask_bit && it.coord_x < FRAME_WIDTH && it.coord_y < FRAME_HEIGHT &&
                it.coord_y >= band_first && it.coord_y < band_end) begin
               if (!needle_seen || it.coord_x < cand_x ||
                   (it.coord_x == cand_x && it.coord_y < cand_y)) begin
                  cand_x      = it.coord_x;
                  cand_y      = it.coord_y;
                  needle_seen = 1'b1;
               end
            end
         end
         OP_BEAD: begin
            // Beads past the limit are dropped without being counted.
            if (beads_seen < MAX_BEADS_DEF) begin
               slot = beads_seen;
               beads_seen++;
               if (it.coord_y > band_first && it.coord_y < band_end) begin
                  dx = (tip_x_held > it.coord_x) ? tip_x_held - it.coord_x
                                                 : it.coord_x - tip_x_held;
                  dy = (tip_y_held > it.coord_y) ? tip_y_held - it.coord_y
                                                 : it.coord_y - tip_y_held;
                  bead_dist = root_floor((dx * dx + dy * dy) * scale_q12 * scale_q12) >> 8;
                  if (bead_dist < nearest_dist) begin
                     nearest_dist = DIST_W'(bead_dist);
                     nearest_idx  = INDEX_W'(slot);
                  end
               end
            end
         end
         OP_MASK_END: begin
            tip_x_held      = needle_seen ? cand_x : X_W'(FRAME_WIDTH);
            tip_y_held      = needle_seen ? cand_y : '0;
            rep.report_kind = REPORT_TIP;
            rep.tip_x       = tip_x_held;
            rep.tip_y       = tip_y_held;
            rep.tip_found   = needle_seen;
            cand_x          = X_W'(FRAME_WIDTH);
            cand_y          = '0;
            needle_seen     = 1'b0;
            expected_reports.push_back(rep);
         end
         default: begin
            rep.report_kind   = REPORT_BEAD;
            rep.tip_x         = tip_x_held;
            rep.tip_y         = tip_y_held;
            rep.tip_found     = (tip_x_held < FRAME_WIDTH);
            rep.distance_um   = nearest_dist;
            rep.closest_index = nearest_idx;
            rep.bead_found    = (nearest_dist < NONE_DIST);
            rep.bead_count    = COUNT_W'(beads_seen);
            nearest_dist      = DIST_W'(NONE_DIST);
            nearest_idx       = '0;
            beads_seen        = 0;
            expected_reports.push_back(rep);
         end
      endcase
   endfunction

   // Driver: offers the next pending item, with random bursts of idling.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if ($urandom_range(0, 63) == 0)
            send_idle_on = !send_idle_on;
         if (send_idle_on && !calm && send_gap == 0 && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 9);
         if (send_gap != 0 || pending_items.size() == 0) begin
            if (send_gap != 0)
               send_gap--;
            req_valid <= 1'b0;
         end else begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Report side: random stall bursts, and one long hold-off on request.
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left     = LONG_HOLD;
      end
      if ($urandom_range(0, 63) == 0)
         recv_idle_on = !recv_idle_on;
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (recv_gap != 0) begin
         recv_gap--;
         rsp_stall <= 1'b1;
      end else if (recv_idle_on && !calm && $urandom_range(0, 5) == 0) begin
         recv_gap = $urandom_range(1, 9) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: checks reports against predictions and predicts new items.
   always @(posedge clock) begin : watch
      rsp_item_type want;
      req_taken <= !reset && req_valid && !req_stall;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRORS)
                  $display("unexpected report: %p", rsp_data);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_data.report_kind !== want.report_kind ||
                   rsp_data.tip_x !== want.tip_x ||
                   rsp_data.tip_y !== want.tip_y ||
                   rsp_data.tip_found !== want.tip_found ||
                   rsp_data.distance_um !== want.distance_um ||
                   rsp_data.closest_index !== want.closest_index ||
                   rsp_data.bead_found !== want.bead_found ||
                   rsp_data.bead_count !== want.bead_count) begin
                  mismatches++;
                  if (mismatches <= SHOWN_ERRORS)
                     $display("report mismatch at cycle %0d:\n  expected %p\n  actual   %p",
                              cycle_count, want, rsp_data);
               end
            end
         end
         if (req_valid && !req_stall)
            predict_item(req_data);
      end
   end

   task automatic push_item(input op_type op, input int unsigned x, input int unsigned y,
                            input bit b);
      req_item_type it;
      it.operation = op;
      it.coord_x   = X_W'(x);
      it.coord_y   = Y_W'(y);
      it.mask_bit  = b;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Picks a row inside the current band, or now and then any row at all.
   function automatic int unsigned band_row();
      int unsigned span;
      span = band_rows;
      if (band_first + span > FRAME_HEIGHT)
         span = FRAME_HEIGHT - band_first;
      if (span == 0 || $urandom_range(0, 5) == 0)
         return $urandom_range(0, FRAME_HEIGHT - 1);
      return band_first + $urandom_range(0, span - 1);
   endfunction

   function automatic int unsigned clip_x(input int x);
      if (x < 0)
         return 0;
      if (x > 2047)
         return 2047;
      return x;
   endfunction

   // Waits until the block has nothing left to do, optionally settling after.
   task automatic drain(input bit settle);
      while (pending_items.size() != 0 || req_valid || expected_reports.size() != 0)
         @(posedge clock);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [1:0] reg_idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      case (reg_idx)
         REG_BAND_TOP:  band_first = value[Y_W-1:0];
         REG_BAND_SIZE: band_rows  = value[SIZE_W-1:0];
         default:       scale_q12  = value[SCALE_W-1:0];
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // One frame and bead set with random content; a few are noise or have
   // their closing item missing.
   task automatic queue_session();
      int unsigned kind;
      int unsigned n;
      int unsigned k;
      int unsigned nx;
      int unsigned reach;
      int unsigned px;
      int unsigned py;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         n = $urandom_range(1, 12);
         for (k = 0; k < n; k++)
            push_item(op_type'(2'($urandom_range(0, 3))), $urandom_range(0, 2047),
                      $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
         return;
      end
      nx = $urandom_range(0, FRAME_WIDTH - 1);
      n  = $urandom_range(1, 20);
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 3))
            0: begin
               px = $urandom_range(0, 2047);
               py = $urandom_range(0, 1023);
            end
            1: begin
               px = nx;
               py = band_row();
            end
            default: begin
               px = clip_x(nx + $urandom_range(0, 60));
               py = band_row();
            end
         endcase
         push_item(OP_PIXEL, px, py, $urandom_range(0, 4) != 0);
      end
      if (kind != 1)
         push_item(OP_MASK_END, $urandom_range(0, 2047), $urandom_range(0, 1023),
                   1'($urandom_range(0, 1)));
      // Keep most beads within reach of the 999 um cut-off for the scale.
      reach = (scale_q12 > 16384) ? 80 : 400;
      n = $urandom_range(0, 8);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) == 0)
            px = $urandom_range(0, 2047);
         else
            px = clip_x(int'(nx) + int'($urandom_range(0, 2 * reach)) - int'(reach));
         push_item(OP_BEAD, px, band_row(), 1'($urandom_range(0, 1)));
      end
      if (kind != 2)
         push_item(OP_BEAD_END, $urandom_range(0, 2047), $urandom_range(0, 1023),
                   1'($urandom_range(0, 1)));
   endtask

   // A bead set longer than the bead limit; the beads past it sit right on
   // the tip and must not win.
   task automatic queue_bead_overflow();
      int unsigned k;
      push_item(OP_PIXEL, 700, 200, 1'b1);
      push_item(OP_MASK_END, 0, 0, 1'b0);
      for (k = 0; k < MAX_BEADS_DEF + 6; k++) begin
         if (k >= MAX_BEADS_DEF)
            push_item(OP_BEAD, 700, 200, 1'b0);
         else if (k == MAX_BEADS_DEF - 1)
            push_item(OP_BEAD, 700, 201, 1'b1);
         else if (k % 40 == 5)
            push_item(OP_BEAD, 700 + k, 150 + k % 200, 1'b0);
         else
            push_item(OP_BEAD, $urandom_range(0, 2047), 100, 1'b0);
      end
      push_item(OP_BEAD_END, 0, 0, 1'b0);
   endtask

   // Stimulus sequence.
   initial begin : stimulus
      int unsigned p;
      int unsigned k;
      int unsigned start;
      int unsigned top;
      int unsigned rows;
      int unsigned scale;
      int unsigned top_tab   [5] = '{0, 1023, 0, 300, 100};
      int unsigned rows_tab  [5] = '{1024, 1, 0, 2047, 300};
      int unsigned scale_tab [5] = '{65535, 1, 2642, 0, 8192};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frame under the reset settings: frame and field extremes,
      // ignored pixels, a column tie, an empty frame, equal bead distances
      // and a bead beyond the 999 um cut-off.
      push_item(OP_PIXEL, 2047, 1023, 1'b1);
      push_item(OP_PIXEL, 1343, 255, 1'b1);
      push_item(OP_PIXEL, 1343, 256, 1'b1);
      push_item(OP_PIXEL, 600, 200, 1'b1);
      push_item(OP_PIXEL, 600, 100, 1'b1);
      push_item(OP_PIXEL, 600, 150, 1'b1);
      push_item(OP_PIXEL, 10, 50, 1'b0);
      push_item(OP_PIXEL, 1344, 0, 1'b1);
      push_item(OP_MASK_END, 0, 0, 1'b0);
      push_item(OP_MASK_END, 2047, 1023, 1'b1);
      push_item(OP_BEAD, 0, 0, 1'b0);
      push_item(OP_BEAD, 2047, 1023, 1'b0);
      push_item(OP_BEAD, 1344, 1, 1'b0);
      push_item(OP_BEAD, 1344, 1, 1'b0);
      push_item(OP_BEAD, 1340, 255, 1'b0);
      push_item(OP_BEAD_END, 0, 0, 1'b0);
      push_item(OP_BEAD_END, 2047, 1023, 1'b1);
      push_item(OP_PIXEL, 0, 0, 1'b1);
      push_item(OP_MASK_END, 0, 0, 1'b0);
      push_item(OP_BEAD, 0, 255, 1'b1);
      push_item(OP_BEAD, 2047, 128, 1'b0);
      push_item(OP_BEAD_END, 0, 0, 1'b0);

      // Random phases, each under its own band and scale.
      for (p = 0; p < NUM_PHASES; p++) begin
         drain(1'b1);
         if (p < 5) begin
            top   = top_tab[p];
            rows  = rows_tab[p];
            scale = scale_tab[p];
         end else begin
            top   = $urandom_range(0, 1023);
            rows  = $urandom_range(1, 1024);
            scale = $urandom_range(1, 65535);
         end
         csr_write(REG_BAND_TOP, top);
         csr_write(REG_BAND_SIZE, rows);
         csr_write(REG_SCALE, scale);
         if (p == OVERFLOW_PHASE)
            queue_bead_overflow();
         if (p == PRESSURE_PHASE) begin
            // Hold the reports back while tip reports keep coming.
            long_hold_req = 1'b1;
            for (k = 0; k < 24; k++) begin
               push_item(OP_PIXEL, $urandom_range(0, 1343), band_row(), 1'b1);
               push_item(OP_PIXEL, $urandom_range(0, 1343), band_row(), 1'b1);
               push_item(OP_MASK_END, 0, 0, 1'b0);
            end
         end
         if (p == NUM_PHASES - 1)
            calm = 1'b1;
         start = items_queued;
         while (items_queued - start < PHASE_ITEMS) begin
            queue_session();
            if ($urandom_range(0, 11) == 0)
               drain(1'b0);
         end
      end

      drain(1'b1);
      if (mismatches == 0 && expected_reports.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
